/* design/assert_macros.svh */
// Assertion macros shared by the line parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* design/scl_pkg.sv */
// Types and constants of the serial command line parser.
package scl_pkg;

	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_DEL   = 8'd127;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_B  = 8'h42;
	localparam logic [7:0] CH_UC_F  = 8'h46;
	localparam logic [7:0] CH_UC_N  = 8'h4E;
	localparam logic [7:0] CH_UC_O  = 8'h4F;

	typedef enum logic [1:0] {
		EV_ECHO     = 2'd0,
		EV_COMMAND  = 2'd1,
		EV_EMPTY    = 2'd2,
		EV_OVERFLOW = 2'd3
	} ev_kind_t;

	typedef enum logic [2:0] {
		CMD_ON      = 3'd0,
		CMD_OFF     = 3'd1,
		CMD_A       = 3'd2,
		CMD_B       = 3'd3,
		CMD_UNKNOWN = 3'd4
	} cmd_t;

	typedef struct packed {
		ev_kind_t   kind;
		logic [7:0] echo;
		cmd_t       code;
	} res_t;

	// up to three results caused by one byte, slot 0 goes out first
	typedef struct packed {
		logic [1:0]  n;
		res_t [2:0]  slot;
		logic [31:0] total;
	} plan_t;

endpackage

/* design/scl_rx_if.sv */
// Receive byte channel.
interface scl_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

/* design/scl_tx_if.sv */
// Result channel.
interface scl_tx_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_kind;
	logic [7:0]  echo_byte;
	logic [2:0]  command_code;
	logic [31:0] received_total;
	logic        last_of_run;

	modport source (output valid, output event_kind, output echo_byte, output command_code,
		output received_total, output last_of_run, input ready);
	modport sink (input valid, input event_kind, input echo_byte, input command_code,
		input received_total, input last_of_run, output ready);
endinterface

/* design/scl_editor.sv */
// Line state, byte counter and per-byte result decode.
`include "assert_macros.svh"
module scl_editor #(
	parameter int LINE_CAPACITY = 10
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     rx_byte,
	output scl_pkg::plan_t plan
);
	import scl_pkg::*;

	localparam int DEPTH = LINE_CAPACITY - 1;
	localparam int LW    = $clog2(DEPTH + 1);
	localparam int IW    = $clog2(DEPTH);

	logic [7:0]    store_q [DEPTH];
	logic [LW-1:0] len_q;
	logic [LW-1:0] len_d;
	logic [31:0]   cnt_q;
	logic          wr_en;
	logic          is_nl;
	logic          is_plain;
	logic          end1;
	logic          end2;
	logic          end3;
	cmd_t          cmd;
	res_t          line_res;

	assign is_nl    = (rx_byte == CH_CR) || (rx_byte == CH_LF);
	assign is_plain = !is_nl && (rx_byte != CH_DEL) && (rx_byte != CH_BS);

	// a word of length k matches only if the line ends, or holds a zero, right after it
	assign end1 = (len_q == LW'(1)) || (store_q[1] == 8'h00);
	assign end2 = (len_q == LW'(2)) || (store_q[2] == 8'h00);
	if (DEPTH > 3) begin : g_end3
		assign end3 = (len_q == LW'(3)) || (store_q[3] == 8'h00);
	end else begin : g_end3_full
		assign end3 = 1'b1;
	end

	always_comb begin
		cmd = CMD_UNKNOWN;
		if (len_q >= LW'(2) && store_q[0] == CH_UC_O && store_q[1] == CH_UC_N && end2)
			cmd = CMD_ON;
		else if (len_q >= LW'(3) && store_q[0] == CH_UC_O && store_q[1] == CH_UC_F
				&& store_q[2] == CH_UC_F && end3)
			cmd = CMD_OFF;
		else if (len_q >= LW'(1) && store_q[0] == CH_UC_A && end1)
			cmd = CMD_A;
		else if (len_q >= LW'(1) && store_q[0] == CH_UC_B && end1)
			cmd = CMD_B;
	end

	always_comb begin
		line_res = '0;
		if (len_q != '0) begin
			line_res.kind = EV_COMMAND;
			line_res.code = cmd;
		end else begin
			line_res.kind = EV_EMPTY;
		end
	end

	always_comb begin
		plan       = '0;
		plan.total = cnt_q + 32'd1;
		len_d      = len_q;
		wr_en      = 1'b0;
		if (is_nl) begin
			len_d = '0;
			if (rx_byte == CH_LF) begin
				plan.n            = 2'd3;
				plan.slot[0].echo = CH_CR;
				plan.slot[1].echo = CH_LF;
				plan.slot[2]      = line_res;
			end else begin
				plan.n       = 2'd1;
				plan.slot[0] = line_res;
			end
		end else if (!is_plain) begin
			if (len_q != '0) begin
				len_d             = len_q - LW'(1);
				plan.n            = 2'd3;
				plan.slot[0].echo = CH_BS;
				plan.slot[1].echo = CH_SPACE;
				plan.slot[2].echo = CH_BS;
			end
		end else begin
			plan.slot[0].echo = rx_byte;
			if (len_q < LW'(DEPTH)) begin
				wr_en  = 1'b1;
				len_d  = len_q + LW'(1);
				plan.n = 2'd1;
			end else begin
				len_d             = '0;
				plan.n            = 2'd2;
				plan.slot[1].kind = EV_OVERFLOW;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			cnt_q <= '0;
		end else if (step) begin
			len_q <= len_d;
			cnt_q <= plan.total;
		end
	end

	always_ff @(posedge clk) begin
		if (step && wr_en)
			store_q[len_q[IW-1:0]] <= rx_byte;
	end

	`ASSERT_IMPLY(a_len_bound, clk, arst_n, 1'b1, len_q <= LW'(DEPTH), "line length beyond store")
	`ASSERT_NEXT(a_nl_clears, clk, arst_n, step && is_nl, len_q == '0, "line kept after newline")
	`ASSERT_NEXT(a_count_step, clk, arst_n, step, cnt_q == $past(cnt_q) + 32'd1, "byte count skipped")

endmodule

/* design/serial_command_line_parser.sv */
// Serial command line parser: top level with input stage and result sequencer.
//
// Usage:
//   rx carries one received byte per beat (rx_byte). tx carries result beats:
//   event_kind, echo_byte, command_code, received_total and last_of_run.
//   Each byte gives zero to three result beats; last_of_run marks the final
//   beat of a byte. A byte that gives none (erase on an empty line) is only
//   counted.
// Order: a byte waits in the input stage until the sequencer is free, is then
//   decoded, and its first result beat is on tx from then on; further beats
//   follow one per cycle while tx.ready is high.
// Overlap: the result sequencer drains one beat a cycle while tx.ready is high,
//   and the next byte is decoded in the cycle its last beat leaves.
// Reset (arst_n low): line empty, byte count zero, both stages empty.
//   The line store is not cleared; only entries below the line length are
//   ever read.
// Stall: while tx.ready is low the pending beat holds; one more byte can
//   still be taken into the input stage, then rx.ready drops.
`include "assert_macros.svh"
module serial_command_line_parser #(
	parameter int LINE_CAPACITY = 10
) (
	input  logic     clk,
	input  logic     arst_n,
	scl_rx_if.sink   rx,
	scl_tx_if.source tx
);
	import scl_pkg::*;

	// input stage
	logic       valid_s1;
	logic [7:0] rx_byte_s1;

	// result sequencer: beats left and their payload
	logic [1:0]  left_q;
	res_t [2:0]  slot_q;
	logic [31:0] total_q;

	plan_t plan;
	logic  tx_take;
	logic  plan_free;
	logic  adv;

	assign tx_take   = tx.valid && tx.ready;
	// sequencer can load when empty or when its last beat leaves now
	assign plan_free = (left_q == 2'd0) || (left_q == 2'd1 && tx_take);
	assign adv       = valid_s1 && plan_free;
	assign rx.ready  = !valid_s1 || adv;

	scl_editor #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_editor (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.rx_byte(rx_byte_s1),
		.plan   (plan)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready)
			rx_byte_s1 <= rx.rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 2'd0;
		end else if (adv) begin
			left_q <= plan.n;
		end else if (tx_take) begin
			left_q <= left_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			slot_q  <= plan.slot;
			total_q <= plan.total;
		end else if (tx_take) begin
			slot_q <= {res_t'(0), slot_q[2:1]};
		end
	end

	assign tx.valid          = (left_q != 2'd0);
	assign tx.event_kind     = slot_q[0].kind;
	assign tx.echo_byte      = slot_q[0].echo;
	assign tx.command_code   = slot_q[0].code;
	assign tx.received_total = total_q;
	assign tx.last_of_run    = (left_q == 2'd1);

	// line events and overflow always end a byte's run
	`ASSERT_IMPLY(a_event_last, clk, arst_n, tx.valid && tx.event_kind != EV_ECHO, tx.last_of_run, "non-echo beat not last")
	// all beats of one byte carry the same count
	`ASSERT_NEXT(a_run_total, clk, arst_n, tx.valid && !(tx.ready && tx.last_of_run), tx.valid && $stable(tx.received_total), "run broken")
	// a waiting byte is not lost or changed
	`ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !adv, valid_s1 && $stable(rx_byte_s1), "input stage dropped")

endmodule

/* sim/testbench.sv */
// Self-checking testbench of the serial command line parser: byte stimulus, echo/event check.
`timescale 1ns / 100ps

module testbench;
	import scl_pkg::*;

	localparam int LINE_CAPACITY = 10;
	localparam int LINE_SLOTS    = LINE_CAPACITY - 1;  // bytes a line can hold
	localparam int RANDOM_BYTES  = 340;

	// one tx beat as the checker sees it
	typedef struct {
		ev_kind_t    kind;
		logic [7:0]  echo;
		cmd_t        code;
		logic [31:0] total;
		logic        last;
	} beat_t;

	// Line editor mirror plus the queue of tx beats still owed by the block.
	class line_scoreboard;
		logic [7:0]  line_buf [LINE_SLOTS];
		int unsigned line_len;
		logic [31:0] byte_count;
		beat_t       owed_q [$];
		int unsigned mismatches;
		int unsigned answered_bytes;  // bytes that caused at least one beat

		function new();
			line_len = 0;
			byte_count = '0;
			mismatches = 0;
			answered_bytes = 0;
		endfunction

		function void owe(ev_kind_t kind, logic [7:0] echo, cmd_t code);
			beat_t b;
			b.kind  = kind;
			b.echo  = echo;
			b.code  = code;
			b.total = byte_count;
			b.last  = 1'b0;
			owed_q.push_back(b);
		endfunction

		// Match stops at the first zero byte, like a C string compare.
		function cmd_t decode_line();
			int n;
			n = 0;
			while (n < line_len && line_buf[n] != 8'h00)
				n++;
			if (n == 2 && line_buf[0] == CH_UC_O && line_buf[1] == CH_UC_N)
				return CMD_ON;
			if (n == 3 && line_buf[0] == CH_UC_O && line_buf[1] == CH_UC_F
					&& line_buf[2] == CH_UC_F)
				return CMD_OFF;
			if (n == 1 && line_buf[0] == CH_UC_A)
				return CMD_A;
			if (n == 1 && line_buf[0] == CH_UC_B)
				return CMD_B;
			return CMD_UNKNOWN;
		endfunction

		// Accepted rx beat: advance the mirror and queue what the block must send.
		function void note_byte(logic [7:0] c);
			int before_n;
			before_n = owed_q.size();
			byte_count = byte_count + 32'd1;
			if (c == CH_CR || c == CH_LF) begin
				if (c == CH_LF) begin
					owe(EV_ECHO, CH_CR, CMD_ON);
					owe(EV_ECHO, CH_LF, CMD_ON);
				end
				if (line_len > 0) begin
					owe(EV_COMMAND, 8'h00, decode_line());
					line_len = 0;
				end else begin
					owe(EV_EMPTY, 8'h00, CMD_ON);
				end
			end else if (c == CH_DEL || c == CH_BS) begin
				// erase on an empty line is counted but silent
				if (line_len > 0) begin
					line_len--;
					owe(EV_ECHO, CH_BS, CMD_ON);
					owe(EV_ECHO, CH_SPACE, CMD_ON);
					owe(EV_ECHO, CH_BS, CMD_ON);
				end
			end else begin
				owe(EV_ECHO, c, CMD_ON);
				if (line_len < LINE_SLOTS) begin
					line_buf[line_len] = c;
					line_len++;
				end else begin
					// full line: echo first, then the discard, byte not kept
					owe(EV_OVERFLOW, 8'h00, CMD_ON);
					line_len = 0;
				end
			end
			if (owed_q.size() > before_n) begin
				owed_q[owed_q.size() - 1].last = 1'b1;
				answered_bytes++;
			end
		endfunction

		function void check_beat(beat_t got);
			beat_t want;
			if (owed_q.size() == 0) begin
				$error("tx beat with nothing owed: kind %0d echo %0d code %0d total %0d",
					got.kind, got.echo, got.code, got.total);
				mismatches++;
				return;
			end
			want = owed_q.pop_front();
			if (got.kind !== want.kind) begin
				$error("event_kind: expected %0d, got %0d", want.kind, got.kind);
				mismatches++;
			end
			if (got.echo !== want.echo) begin
				$error("echo_byte: expected %0d, got %0d", want.echo, got.echo);
				mismatches++;
			end
			if (got.code !== want.code) begin
				$error("command_code: expected %0d, got %0d", want.code, got.code);
				mismatches++;
			end
			if (got.total !== want.total) begin
				$error("received_total: expected %0d, got %0d", want.total, got.total);
				mismatches++;
			end
			if (got.last !== want.last) begin
				$error("last_of_run: expected %0d, got %0d", want.last, got.last);
				mismatches++;
			end
		endfunction

		function int pending();
			return owed_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	scl_rx_if rx ();
	scl_tx_if tx ();

	serial_command_line_parser #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.tx(tx)
	);

	line_scoreboard sb;
	bit rx_calm;  // set for stretches where the sender never idles

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Idle length: mostly none or short, now and then long.
	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Any byte that the editor stores (no CR, LF, BS, DEL).
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CH_CR || b == CH_LF || b == CH_BS || b == CH_DEL);
		return b;
	endfunction

	function automatic logic [7:0] line_end();
		return $urandom_range(0, 1) ? CH_CR : CH_LF;
	endfunction

	function automatic logic [7:0] erase_key();
		return $urandom_range(0, 1) ? CH_BS : CH_DEL;
	endfunction

	// One rx beat. Called right after a rising edge; returns right after the
	// edge that took the beat. valid stays high between back-to-back beats so
	// it is never lowered and raised in the same step.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = rx_calm ? 0 : idle_cycles();
		if (gap > 0) begin
			rx.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx.valid   <= 1'b1;
		rx.rx_byte <= b;
		@(posedge clk);
		while (!rx.ready)
			@(posedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// A command word with random decoration: typo fixed by erase, stray tail,
	// or a zero byte that cuts the compare short.
	task automatic send_command_line();
		string words [4];
		int    pick;
		int    r;
		words[0] = "ON";
		words[1] = "OFF";
		words[2] = "A";
		words[3] = "B";
		pick = $urandom_range(0, 3);
		r = $urandom_range(0, 9);
		if (r == 0) begin
			send_byte(plain_byte());
			send_byte(erase_key());
		end
		send_text(words[pick]);
		if (r == 1) begin
			send_byte(plain_byte());
			send_byte(erase_key());
		end else if (r == 2) begin
			send_byte(plain_byte());  // tail makes the word unknown (most of the time)
		end else if (r == 3) begin
			send_byte(8'h00);
			repeat ($urandom_range(0, 3)) send_byte(plain_byte());
		end
		send_byte(line_end());
	endtask

	task automatic send_random_line();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			send_command_line();
		end else if (r < 68) begin
			// junk line, possibly empty
			repeat ($urandom_range(0, LINE_SLOTS - 1)) send_byte(plain_byte());
			send_byte(line_end());
		end else if (r < 80) begin
			// runs past the capacity: overflow, then a fresh partial line
			repeat ($urandom_range(LINE_SLOTS + 1, LINE_SLOTS + 4)) send_byte(plain_byte());
			send_byte(line_end());
		end else if (r < 90) begin
			// erases that may outnumber the characters, so some land on an empty line
			repeat ($urandom_range(0, 3)) send_byte(plain_byte());
			repeat ($urandom_range(1, 5)) send_byte(erase_key());
			if ($urandom_range(0, 1))
				send_text("ON");
			send_byte(line_end());
		end else begin
			// raw noise over the whole byte range
			repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// Result side: ready high for a while, then a stall of random length.
	// Every pass starts on a clock edge and assigns ready once there.
	initial begin
		int stall;
		forever begin
			tx.ready <= 1'b1;
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(30, 80)) @(posedge clk);
			else
				repeat ($urandom_range(1, 10)) @(posedge clk);
			stall = idle_cycles();
			if (stall > 0) begin
				tx.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Both handshakes are sampled at the edge with pre-edge values. Checking
	// goes first; a byte taken at this edge cannot have a beat out yet anyway.
	always @(posedge clk) begin
		beat_t got;
		if (arst_n) begin
			if (tx.valid && tx.ready) begin
				got.kind  = ev_kind_t'(tx.event_kind);
				got.echo  = tx.echo_byte;
				got.code  = cmd_t'(tx.command_code);
				got.total = tx.received_total;
				got.last  = tx.last_of_run;
				sb.check_beat(got);
			end
			if (rx.valid && rx.ready)
				sb.note_byte(rx.rx_byte);
		end
	end

	initial begin
		int unsigned base;
		int          drain;
		sb = new();
		rx_calm = 1'b0;
		arst_n <= 1'b0;
		rx.valid <= 1'b0;
		rx.rx_byte <= 8'h00;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		send_byte(CH_CR);              // empty line, no echo
		send_byte(CH_LF);              // empty line after CR LF echo
		send_byte(CH_BS);              // erase on empty line: silent
		send_byte(CH_DEL);
		send_text("ON");
		send_byte(CH_CR);
		send_text("OFX");
		send_byte(CH_DEL);             // erase on a non-empty line
		send_text("F");
		send_byte(CH_LF);
		send_text("A");
		send_byte(CH_CR);
		send_text("B");
		send_byte(8'h00);              // zero byte ends the compare: still B
		send_byte(8'hFF);
		send_byte(CH_BS);
		send_byte(CH_LF);
		send_byte(8'h00);              // line starting with zero: unknown
		send_byte(CH_CR);
		send_text("OVERFLOW9");        // fills the line
		send_byte(8'h5A);              // one past: echo plus discard
		send_byte(CH_CR);              // line was cleared, so empty

		// Random part: mostly well-formed lines, some noise.
		base = sb.answered_bytes;
		while (sb.answered_bytes - base < RANDOM_BYTES) begin
			rx_calm = ($urandom_range(0, 5) == 0);
			send_random_line();
		end
		rx.valid <= 1'b0;
		// let the monitor book the last byte before looking at the queue
		@(posedge clk);

		while (sb.pending() != 0)
			@(posedge clk);
		// keep clocking a while longer in case stray beats follow
		for (drain = 0; drain < 20; drain++)
			@(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#1_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
